// ===== hw/rtl/mexp_pkg.sv =====
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared types and constants of the modular exponentiation block.
// ----------------------------------------------------------------------------
`default_nettype none

package mexp_pkg;

	localparam int MOD_WIDTH_DEF = 32;
	localparam int DATA_W        = 32;
	localparam int CFG_IDX_W     = 1;

	localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 1'b1;

	localparam logic [DATA_W-1:0] MODULUS_RST  = 32'd2;
	localparam logic [DATA_W-1:0] EXPONENT_RST = 32'd1;

	typedef enum logic [1:0] {
		OP_REDUCE,
		OP_MUL,
		OP_SQR
	} mexp_op_t;

	typedef struct packed {
		logic     load;
		logic     zero_r;
		logic     mul_start;
		mexp_op_t op;
		logic     out_load;
	} mexp_cmd_t;

	typedef struct packed {
		logic m_small;
		logic e_zero;
		logic e_lsb;
		logic mul_done;
	} mexp_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mexp_mulmod.sv =====
// ----------------------------------------------------------------------------
// mexp_mulmod
// Shift-and-add modular multiplier: each operand bit takes a doubling step and then a conditional add step.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_mulmod #(
	parameter int W   = mexp_pkg::MOD_WIDTH_DEF,
	parameter int OPW = (W > mexp_pkg::DATA_W) ? W : mexp_pkg::DATA_W
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic [W-1:0]   a,
	input  wire logic [OPW-1:0] b,
	input  wire logic [W-1:0]   m,
	output logic                done,
	output logic      [W-1:0]   result
);

	localparam int CW = $clog2(OPW);

	logic [W-1:0]   acc_q;
	logic [W-1:0]   a_q;
	logic [W-1:0]   m_q;
	logic [OPW-1:0] b_q;
	logic [CW-1:0]  cnt_q;
	logic           phase_q;
	logic           busy_q;
	logic           done_q;

	logic [W-1:0]   addend;
	logic [W:0]     sum;
	logic [W:0]     red;

	always_comb begin
		addend = phase_q ? a_q : acc_q;
		sum    = {1'b0, acc_q} + {1'b0, addend};
		red    = (sum >= {1'b0, m_q}) ? (sum - {1'b0, m_q}) : sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= 1'b0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				phase_q <= 1'b0;
				cnt_q   <= CW'(OPW - 1);
			end else if (busy_q) begin
				phase_q <= ~phase_q;
				if (phase_q) begin
					if (cnt_q == '0) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
			m_q   <= m;
		end else if (busy_q) begin
			if (!phase_q) begin
				acc_q <= red[W-1:0];
			end else begin
				if (b_q[OPW-1]) begin
					acc_q <= red[W-1:0];
				end
				b_q <= {b_q[OPW-2:0], 1'b0};
			end
		end
	end

	assign done   = done_q;
	assign result = acc_q;

endmodule

`default_nettype wire

// ===== hw/rtl/mexp_dp.sv =====
// ----------------------------------------------------------------------------
// mexp_dp
// Datapath: configuration registers, exponent scan, running result and base
// power, and the shared modular multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_dp #(
	parameter int MOD_WIDTH = mexp_pkg::MOD_WIDTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_write_en,
	input  wire logic [mexp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [mexp_pkg::DATA_W-1:0]      cfg_data,
	input  wire logic [mexp_pkg::DATA_W-1:0]      base_value,
	input  wire mexp_pkg::mexp_cmd_t              cmd,
	output mexp_pkg::mexp_sts_t                   sts,
	output logic      [mexp_pkg::DATA_W-1:0]      power_result
);

	localparam int W   = MOD_WIDTH;
	localparam int DW  = mexp_pkg::DATA_W;
	localparam int OPW = (W > DW) ? W : DW;

	logic [DW-1:0]      modulus_q;
	logic [DW-1:0]      exponent_q;
	logic [W-1:0]       m_q;
	logic [DW-1:0]      e_q;
	logic [W-1:0]       r_q;
	logic [W-1:0]       b_q;
	logic [DW-1:0]      base_q;
	mexp_pkg::mexp_op_t op_q;
	logic [DW-1:0]      power_result_q;

	logic [OPW-1:0]     mod_ext;
	logic [OPW-1:0]     r_ext;
	logic [W-1:0]       mul_a;
	logic [OPW-1:0]     mul_b;
	logic               mul_done;
	logic [W-1:0]       mul_res;

	assign mod_ext = OPW'(modulus_q);
	assign r_ext   = OPW'(r_q);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q  <= mexp_pkg::MODULUS_RST;
			exponent_q <= mexp_pkg::EXPONENT_RST;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				mexp_pkg::REG_MODULUS:  modulus_q  <= cfg_data;
				mexp_pkg::REG_EXPONENT: exponent_q <= cfg_data;
			endcase
		end
	end

	always_comb begin
		case (cmd.op)
			mexp_pkg::OP_MUL: begin
				mul_a = r_q;
				mul_b = OPW'(b_q);
			end
			mexp_pkg::OP_SQR: begin
				mul_a = b_q;
				mul_b = OPW'(b_q);
			end
			default: begin
				mul_a = W'(1);
				mul_b = OPW'(base_q);
			end
		endcase
	end

	mexp_mulmod #(
		.W   (W),
		.OPW (OPW)
	) u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.m      (m_q),
		.done   (mul_done),
		.result (mul_res)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			m_q    <= mod_ext[W-1:0];
			e_q    <= exponent_q;
			r_q    <= W'(1);
			base_q <= base_value;
		end else begin
			if (cmd.zero_r) begin
				r_q <= '0;
			end
			if (cmd.mul_start) begin
				op_q <= cmd.op;
			end
			if (mul_done) begin
				case (op_q)
					mexp_pkg::OP_MUL: r_q <= mul_res;
					mexp_pkg::OP_SQR: begin
						b_q <= mul_res;
						e_q <= {1'b0, e_q[DW-1:1]};
					end
					default: b_q <= mul_res;
				endcase
			end
		end
		if (cmd.out_load) begin
			power_result_q <= r_ext[DW-1:0];
		end
	end

	always_comb begin
		sts.m_small  = (m_q[W-1:1] == '0);
		sts.e_zero   = (e_q == '0);
		sts.e_lsb    = e_q[0];
		sts.mul_done = mul_done;
	end

	assign power_result = power_result_q;

endmodule

`default_nettype wire

// ===== hw/rtl/mexp_ctrl.sv =====
// ----------------------------------------------------------------------------
// mexp_ctrl
// Controller: sequences base reduction and the square-and-multiply scan,
// and owns both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	output logic                     out_valid,
	input  wire logic                out_stall,
	input  wire mexp_pkg::mexp_sts_t sts,
	output mexp_pkg::mexp_cmd_t      cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_WAIT_RED,
		S_STEP,
		S_WAIT_MUL,
		S_SQR,
		S_WAIT_SQR,
		S_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	always_comb begin
		cmd           = '0;
		cmd.op        = mexp_pkg::OP_REDUCE;
		cmd.load      = (state_q == S_IDLE) && in_valid;
		cmd.zero_r    = (state_q == S_CHECK) && sts.m_small;
		cmd.out_load  = (state_q == S_DONE) && (!out_valid_q || !out_stall);
		unique case (state_q)
			S_CHECK: begin
				cmd.mul_start = !sts.m_small;
				cmd.op        = mexp_pkg::OP_REDUCE;
			end
			S_STEP: begin
				cmd.mul_start = !sts.e_zero && sts.e_lsb;
				cmd.op        = mexp_pkg::OP_MUL;
			end
			S_SQR: begin
				cmd.mul_start = 1'b1;
				cmd.op        = mexp_pkg::OP_SQR;
			end
			default: begin
				cmd.mul_start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					state_q <= sts.m_small ? S_DONE : S_WAIT_RED;
				end
				S_WAIT_RED: begin
					if (sts.mul_done) begin
						state_q <= S_STEP;
					end
				end
				S_STEP: begin
					if (sts.e_zero) begin
						state_q <= S_DONE;
					end else if (sts.e_lsb) begin
						state_q <= S_WAIT_MUL;
					end else begin
						state_q <= S_SQR;
					end
				end
				S_WAIT_MUL: begin
					if (sts.mul_done) begin
						state_q <= S_SQR;
					end
				end
				S_SQR: begin
					state_q <= S_WAIT_SQR;
				end
				S_WAIT_SQR: begin
					if (sts.mul_done) begin
						state_q <= S_STEP;
					end
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== hw/rtl/modular_exponentiation.sv =====
// ----------------------------------------------------------------------------
// modular_exponentiation
// Raises each base value to the configured exponent modulo the configured
// modulus by right-to-left square-and-multiply.
// ----------------------------------------------------------------------------
// One transaction is worked on at a time. All arithmetic goes through a single
// shift-and-add modular multiplier that works through OPW operand bits per
// product, OPW being the larger of MOD_WIDTH and 32. A transaction costs
// (1 + L + P) products, where L is the bit length of the exponent and P its
// number of set bits: one product reduces the base, one squaring is done per
// exponent bit and one multiply per set bit. A modulus below 2 gives 0 with no
// product. The finished result sits in an output register, so the next base is
// taken while it waits. The user must write the registers only while no
// transaction is open; the block itself does not enforce it.
`default_nettype none

module modular_exponentiation #(
	parameter int MOD_WIDTH = mexp_pkg::MOD_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_write_en,
	input  wire logic [mexp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [mexp_pkg::DATA_W-1:0]    cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [mexp_pkg::DATA_W-1:0]    base_value,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic      [mexp_pkg::DATA_W-1:0]    power_result
);

	mexp_pkg::mexp_cmd_t cmd;
	mexp_pkg::mexp_sts_t sts;

	mexp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	mexp_dp #(
		.MOD_WIDTH (MOD_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.base_value   (base_value),
		.cmd          (cmd),
		.sts          (sts),
		.power_result (power_result)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/mexp_checker.sv =====
// ----------------------------------------------------------------------------
// mexp_checker
// Port-level checks of the modular exponentiation block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           in_valid,
	input wire logic                           in_stall,
	input wire logic                           out_valid,
	input wire logic                           out_stall,
	input wire logic [mexp_pkg::DATA_W-1:0]    power_result
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(power_result))
		else $error("result changed while stalled");

	// one transaction at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second transaction taken while busy");

	// no result straight after an accept
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !$rose(out_valid))
		else $error("result raised without computation");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (.*);

`default_nettype wire

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the modular exponentiation block. Every accepted base value gets its
// expected power, worked out from the modulus and exponent in force. Each
// returned transaction is compared with the oldest expected power. Directed
// cases cover extreme operands, a zero exponent and moduli below two. Random
// settings and bases follow under phases of sender idling and receiver
// stalling.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MOD_W       = mexp_pkg::MOD_WIDTH_DEF;
	localparam int QUIET_LIMIT = 20000;

	logic                                clk          = 1'b0;
	logic                                arst_n       = 1'b0;
	logic                                cfg_write_en = 1'b0;
	logic [mexp_pkg::CFG_IDX_W-1:0]      cfg_index    = mexp_pkg::REG_MODULUS;
	logic [mexp_pkg::DATA_W-1:0]         cfg_data     = '0;
	logic                                in_valid     = 1'b0;
	logic                                in_stall;
	logic [mexp_pkg::DATA_W-1:0]         base_value   = '0;
	logic                                out_valid;
	logic                                out_stall    = 1'b0;
	logic [mexp_pkg::DATA_W-1:0]         power_result;

	logic [31:0] modulus_setting  = mexp_pkg::MODULUS_RST;
	logic [31:0] exponent_setting = mexp_pkg::EXPONENT_RST;
	logic [31:0] base_queue[$];
	logic [31:0] expected_powers[$];
	logic [31:0] wanted_power;
	logic [31:0] next_modulus;
	logic [31:0] next_exponent;
	int          send_idle_pct  = 0;
	int          recv_stall_pct = 0;
	int          mismatches     = 0;
	int          quiet_cycles   = 0;

	modular_exponentiation uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.base_value   (base_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.power_result (power_result)
	);

	always #5 clk = ~clk;

	function automatic logic [31:0] compute_power(input logic [31:0] base,
			input logic [31:0] m_reg, input logic [31:0] e_reg);
		logic [63:0] m;
		logic [63:0] b;
		logic [63:0] r;
		logic [31:0] e;
		m = {32'd0, m_reg};
		if (MOD_W < 32)
			m = m & ((64'd1 << MOD_W) - 64'd1);
		if (m < 64'd2)
			return '0;
		b = {32'd0, base} % m;
		r = 64'd1;
		e = e_reg;
		while (e != 0) begin
			if (e[0])
				r = (r * b) % m;
			e = e >> 1;
			b = (b * b) % m;
		end
		return r[31:0];
	endfunction

	task automatic add_base(input logic [31:0] v);
		base_queue.insert(base_queue.size(), v);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (base_queue.size() != 0 || in_valid || expected_powers.size() != 0)
			@(negedge clk);
	endtask

	task automatic apply_config(input logic [31:0] m, input logic [31:0] e);
		wait_idle();
		@(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_index    <= mexp_pkg::REG_MODULUS;
		cfg_data     <= m;
		@(posedge clk);
		cfg_index    <= mexp_pkg::REG_EXPONENT;
		cfg_data     <= e;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		modulus_setting  = m;
		exponent_setting = e;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			base_value <= '0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid)
				expected_powers.insert(expected_powers.size(),
					compute_power(base_value, modulus_setting, exponent_setting));
			if (base_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid   <= 1'b1;
				base_value <= base_queue.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor and watchdog
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall    <= 1'b0;
			quiet_cycles <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_powers.size() == 0) begin
					$error("power_result: unexpected transaction, expected none, actual %h",
						power_result);
					mismatches++;
				end else begin
					wanted_power = expected_powers.pop_front();
					if (power_result !== wanted_power) begin
						$error("power_result: expected %h, actual %h", wanted_power,
							power_result);
						mismatches++;
					end
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings
		add_base(32'h0000_0000);
		add_base(32'h0000_0001);
		add_base(32'hFFFF_FFFF);

		// widest modulus and exponent
		apply_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_base(32'h0000_0000);
		add_base(32'h0000_0001);
		add_base(32'hFFFF_FFFE);
		add_base(32'hFFFF_FFFF);
		add_base(32'h8000_0000);

		// zero exponent
		apply_config(32'hFFFF_FFFB, 32'h0000_0000);
		add_base(32'h0000_0000);
		add_base(32'h0000_0005);
		add_base(32'hFFFF_FFFF);

		// moduli below two
		apply_config(32'h0000_0000, 32'hFFFF_FFFF);
		add_base(32'hDEAD_BEEF);
		add_base(32'h0000_0007);
		apply_config(32'h0000_0001, 32'h0000_0003);
		add_base(32'hFFFF_FFFF);
		add_base(32'h0000_0000);

		// small key pair, encrypt then decrypt
		apply_config(32'd3233, 32'd17);
		add_base(32'd65);
		apply_config(32'd3233, 32'd2753);
		add_base(32'd2790);
		apply_config(32'd2, 32'd0);
		add_base(32'hFFFF_FFFF);

		for (int phase = 0; phase < 4; phase++) begin
			wait_idle();
			case (phase)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 51;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 51;
				end
				default: begin
					send_idle_pct  = 37;
					recv_stall_pct = 37;
				end
			endcase
			repeat (5) begin
				case ($urandom_range(4))
					0:       next_modulus = $urandom_range(255, 2);
					1:       next_modulus = $urandom | 32'h8000_0000;
					2:       next_modulus = $urandom >> $urandom_range(31);
					3:       next_modulus = 32'hFFFF_FFFF;
					default: next_modulus = $urandom;
				endcase
				// mostly short exponents, the odd full-width one
				case ($urandom_range(9))
					0:       next_exponent = 32'h0000_0000;
					1:       next_exponent = 32'hFFFF_FFFF;
					2:       next_exponent = $urandom;
					default: next_exponent = $urandom >> $urandom_range(31, 20);
				endcase
				apply_config(next_modulus, next_exponent);
				repeat (6) begin
					if ($urandom_range(3) == 0)
						add_base($urandom_range(3));
					else
						add_base($urandom);
				end
			end
		end

		wait_idle();
		repeat (100) @(posedge clk);
		if (mismatches == 0 && expected_powers.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire
